>>> design/psz_pkg.sv
// Shared types, constants and bit-scan helpers for the page size selector.
// Used by every module of the page_size_selector_unit pipeline.
`default_nettype none

package psz_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned SHIFT_W = 6;

  // 4 KiB, 2 MiB and 1 GiB supported out of reset
  localparam logic [DATA_W-1:0] MASK_RESET = 64'h0000_0000_4020_1000;

  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd63;

  typedef enum logic [2:0] {
    OP_ENCOMPASS = 3'd0,
    OP_FIT       = 3'd1,
    OP_AT_ADDR   = 3'd2,
    OP_INCREASE  = 3'd3,
    OP_DECREASE  = 3'd4
  } op_e_t;

  // Stage 2 result: operands decoded to shifts
  typedef struct packed {
    logic               valid;
    logic [2:0]         op;
    logic [SHIFT_W-1:0] given;
    logic [SHIFT_W:0]   ceil_shift;   // 0..64
    logic [SHIFT_W-1:0] addr_shift;
    logic               addr_zero;
    logic [SHIFT_W-1:0] lo;
    logic [SHIFT_W-1:0] hi;
    logic               mask_nz;
  } prep_t;

  // Stage 4 result: both mask searches done
  typedef struct packed {
    logic               valid;
    logic [2:0]         op;
    logic [SHIFT_W-1:0] given;
    logic [SHIFT_W-1:0] clamp_shift;
    logic               up_found;
    logic [SHIFT_W-1:0] up_idx;
    logic               dn_found;
    logic [SHIFT_W-1:0] dn_idx;
    logic               mask_nz;
  } srch_t;

  // Keep only the lowest set bit
  function automatic logic [DATA_W-1:0] isolate_low(input logic [DATA_W-1:0] v);
    return v & (~v + {{(DATA_W-1){1'b0}}, 1'b1});
  endfunction

  function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = v[DATA_W-1-i];
    end
    return r;
  endfunction

  // Encode a one-hot word into its bit index
  function automatic logic [SHIFT_W-1:0] onehot_index(input logic [DATA_W-1:0] v);
    logic [SHIFT_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < SHIFT_W; j++) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (((i >> j) & 1) == 1) begin
          idx[j] = idx[j] | v[i];
        end
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> design/page_size_selector_unit.sv
// Top level of the page size selector: config register and a five-stage query pipeline.
// Depends on psz_pkg, psz_prep, psz_search and psz_select.
//
//  channel  | ports                                                  | transfer
//  ---------+--------------------------------------------------------+----------------------
//  query    | start, busy, in_operation, in_byte_count,              | start & !busy
//           | in_start_address, in_given_shift                       |
//  result   | out_valid, out_size_shift, out_found                   | out_valid, one cycle
//  config   | cfg_we, cfg_wdata                                      | cfg_we
//
// One query enters per cycle; busy is never raised. A result passes through five register
// stages: operand decrement and bit isolation, index encoding, clamp and window masking,
// mask scan, answer select.
// Synchronous active-low reset clears the valid bits and loads the default size mask.
// The receiver takes every result on its strobe cycle, so nothing stalls.
`default_nettype none

module page_size_selector_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   in_operation,
  input  wire logic [psz_pkg::DATA_W-1:0]   in_byte_count,
  input  wire logic [psz_pkg::DATA_W-1:0]   in_start_address,
  input  wire logic [psz_pkg::SHIFT_W-1:0]  in_given_shift,
  output logic                              out_valid,
  output logic [psz_pkg::SHIFT_W-1:0]       out_size_shift,
  output logic                              out_found,
  input  wire logic                         cfg_we,
  input  wire logic [psz_pkg::DATA_W-1:0]   cfg_wdata
);
  import psz_pkg::*;

  logic [DATA_W-1:0] mask_r;
  logic              in_valid;
  prep_t             prep;
  srch_t             srch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  psz_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_operation),
    .in_bytes (in_byte_count),
    .in_addr  (in_start_address),
    .in_given (in_given_shift),
    .mask     (mask_r),
    .prep     (prep)
  );

  psz_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .prep  (prep),
    .mask  (mask_r),
    .srch  (srch)
  );

  psz_select u_select (
    .clk            (clk),
    .rst_n          (rst_n),
    .srch           (srch),
    .out_valid      (out_valid),
    .out_size_shift (out_size_shift),
    .out_found      (out_found)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result strobe without a transaction five cycles earlier");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_size_shift == '0))
    else $error("size shift not zero when no size found");

  a_found_qual: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_found)
    else $error("found raised outside a result strobe");
`endif

endmodule

`default_nettype wire

>>> design/psz_prep.sv
// Front two pipeline stages: decrement, bit isolation and index encoding of operands.
// Depends on psz_pkg.
`default_nettype none

module psz_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [2:0]                   in_op,
  input  wire logic [psz_pkg::DATA_W-1:0]   in_bytes,
  input  wire logic [psz_pkg::DATA_W-1:0]   in_addr,
  input  wire logic [psz_pkg::SHIFT_W-1:0]  in_given,
  input  wire logic [psz_pkg::DATA_W-1:0]   mask,
  output psz_pkg::prep_t                    prep
);
  import psz_pkg::*;

  // stage 1
  logic                v1_r;
  logic [2:0]          op1_r;
  logic [SHIFT_W-1:0]  given1_r;
  logic [DATA_W-1:0]   dec1_r;
  logic                gt1_1_r;
  logic [DATA_W-1:0]   addr_oh1_r;
  logic                addr_zero1_r;
  logic [DATA_W-1:0]   lo_oh1_r;
  logic [DATA_W-1:0]   hi_ohr1_r;
  logic                nz1_r;

  // stage 2
  prep_t               prep_r;
  prep_t               prep_nxt;
  logic [SHIFT_W-1:0]  dec_top;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op1_r        <= in_op;
    given1_r     <= in_given;
    dec1_r       <= in_bytes - {{(DATA_W-1){1'b0}}, 1'b1};
    gt1_1_r      <= |in_bytes[DATA_W-1:1];
    addr_oh1_r   <= isolate_low(in_addr);
    addr_zero1_r <= (in_addr == '0);
    lo_oh1_r     <= isolate_low(mask);
    hi_ohr1_r    <= isolate_low(bit_rev(mask));
    nz1_r        <= |mask;
  end

  always_comb begin
    // highest set bit of count-1, found from the reversed word
    dec_top               = ~onehot_index(isolate_low(bit_rev(dec1_r)));
    prep_nxt.valid        = v1_r;
    prep_nxt.op           = op1_r;
    prep_nxt.given        = given1_r;
    prep_nxt.ceil_shift   = gt1_1_r ? ({1'b0, dec_top} + {{SHIFT_W{1'b0}}, 1'b1}) : '0;
    prep_nxt.addr_shift   = onehot_index(addr_oh1_r);
    prep_nxt.addr_zero    = addr_zero1_r;
    prep_nxt.lo           = onehot_index(lo_oh1_r);
    prep_nxt.hi           = ~onehot_index(hi_ohr1_r);
    prep_nxt.mask_nz      = nz1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else begin
      prep_r.valid <= prep_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    prep_r.op         <= prep_nxt.op;
    prep_r.given      <= prep_nxt.given;
    prep_r.ceil_shift <= prep_nxt.ceil_shift;
    prep_r.addr_shift <= prep_nxt.addr_shift;
    prep_r.addr_zero  <= prep_nxt.addr_zero;
    prep_r.lo         <= prep_nxt.lo;
    prep_r.hi         <= prep_nxt.hi;
    prep_r.mask_nz    <= prep_nxt.mask_nz;
  end

  assign prep = prep_r;

endmodule

`default_nettype wire

>>> design/psz_search.sv
// Middle two pipeline stages: clamp, build search windows over the mask, scan them.
// Depends on psz_pkg.
`default_nettype none

module psz_search (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire psz_pkg::prep_t              prep,
  input  wire logic [psz_pkg::DATA_W-1:0]  mask,
  output psz_pkg::srch_t                   srch
);
  import psz_pkg::*;

  logic [SHIFT_W-1:0] clamp_s;
  logic               up_en;
  logic [SHIFT_W-1:0] up_t;
  logic               dn_en;
  logic [SHIFT_W-1:0] dn_u;

  // stage 3
  logic               v3_r;
  logic [2:0]         op3_r;
  logic [SHIFT_W-1:0] given3_r;
  logic [SHIFT_W-1:0] s3_r;
  logic               nz3_r;
  logic [DATA_W-1:0]  up_mask3_r;
  logic [DATA_W-1:0]  dn_mask3_r;

  // stage 4
  srch_t              srch_r;
  srch_t              srch_nxt;

  always_comb begin
    // clamp the rounded-up size into [lo, hi]
    if (prep.ceil_shift < {1'b0, prep.lo}) begin
      clamp_s = prep.lo;
    end else if (prep.ceil_shift > {1'b0, prep.hi}) begin
      clamp_s = prep.hi;
    end else begin
      clamp_s = prep.ceil_shift[SHIFT_W-1:0];
    end
  end

  always_comb begin
    up_en = 1'b0;
    up_t  = '0;
    dn_en = 1'b0;
    dn_u  = '0;
    case (prep.op)
      OP_ENCOMPASS: begin
        up_en = 1'b1;
        up_t  = clamp_s;
      end
      OP_FIT: begin
        dn_en = 1'b1;
        dn_u  = clamp_s;
      end
      OP_AT_ADDR: begin
        up_en = 1'b1;
        up_t  = clamp_s;
        dn_en = 1'b1;
        // address zero caps nothing: search the whole mask
        dn_u  = prep.addr_zero ? SHIFT_MAX : prep.addr_shift;
      end
      OP_INCREASE: begin
        up_en = (prep.given != SHIFT_MAX);
        up_t  = prep.given + {{(SHIFT_W-1){1'b0}}, 1'b1};
      end
      OP_DECREASE: begin
        dn_en = (prep.given != '0);
        dn_u  = prep.given - {{(SHIFT_W-1){1'b0}}, 1'b1};
      end
      default: begin
        up_en = 1'b0;
        dn_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= prep.valid;
    end
  end

  always_ff @(posedge clk) begin
    op3_r      <= prep.op;
    given3_r   <= prep.given;
    s3_r       <= clamp_s;
    nz3_r      <= prep.mask_nz;
    up_mask3_r <= mask & ({DATA_W{1'b1}} << up_t) & {DATA_W{up_en}};
    dn_mask3_r <= mask & ({DATA_W{1'b1}} >> (SHIFT_MAX - dn_u)) & {DATA_W{dn_en}};
  end

  always_comb begin
    srch_nxt.valid       = v3_r;
    srch_nxt.op          = op3_r;
    srch_nxt.given       = given3_r;
    srch_nxt.clamp_shift = s3_r;
    srch_nxt.up_found    = |up_mask3_r;
    srch_nxt.up_idx      = onehot_index(isolate_low(up_mask3_r));
    srch_nxt.dn_found    = |dn_mask3_r;
    srch_nxt.dn_idx      = ~onehot_index(isolate_low(bit_rev(dn_mask3_r)));
    srch_nxt.mask_nz     = nz3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r.valid <= 1'b0;
    end else begin
      srch_r.valid <= srch_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    srch_r.op          <= srch_nxt.op;
    srch_r.given       <= srch_nxt.given;
    srch_r.clamp_shift <= srch_nxt.clamp_shift;
    srch_r.up_found    <= srch_nxt.up_found;
    srch_r.up_idx      <= srch_nxt.up_idx;
    srch_r.dn_found    <= srch_nxt.dn_found;
    srch_r.dn_idx      <= srch_nxt.dn_idx;
    srch_r.mask_nz     <= srch_nxt.mask_nz;
  end

  assign srch = srch_r;

endmodule

`default_nettype wire

>>> design/psz_select.sv
// Last pipeline stage: pick the answer per operation and register the result port.
// Depends on psz_pkg.
`default_nettype none

module psz_select (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire psz_pkg::srch_t               srch,
  output logic                              out_valid,
  output logic [psz_pkg::SHIFT_W-1:0]       out_size_shift,
  output logic                              out_found
);
  import psz_pkg::*;

  logic               found;
  logic [SHIFT_W-1:0] res;
  logic               valid_r;
  logic               found_r;
  logic [SHIFT_W-1:0] shift_r;

  always_comb begin
    found = 1'b0;
    res   = '0;
    if (srch.mask_nz) begin
      case (srch.op) inside
        OP_ENCOMPASS, OP_INCREASE: begin
          found = srch.up_found;
          res   = srch.up_idx;
        end
        OP_FIT, OP_DECREASE: begin
          found = srch.dn_found;
          res   = srch.dn_idx;
        end
        OP_AT_ADDR: begin
          if (!srch.dn_found) begin
            found = 1'b0;
          end else if (srch.clamp_shift > srch.dn_idx) begin
            // alignment caps the size
            found = 1'b1;
            res   = srch.dn_idx;
          end else begin
            found = srch.up_found;
            res   = srch.up_idx;
          end
        end
        default: begin
          found = 1'b0;
        end
      endcase
    end
    if (!found) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      valid_r <= srch.valid;
      found_r <= srch.valid & found;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= res;
  end

  assign out_valid      = valid_r;
  assign out_found      = found_r;
  assign out_size_shift = shift_r;

`ifndef SYNTHESIS
  a_inc_above: assert property (@(posedge clk) disable iff (!rst_n)
    (srch.valid && srch.op == OP_INCREASE && srch.up_found) |-> (srch.up_idx > srch.given))
    else $error("increase picked a size not above the given one");

  a_dec_below: assert property (@(posedge clk) disable iff (!rst_n)
    (srch.valid && srch.op == OP_DECREASE && srch.dn_found) |-> (srch.dn_idx < srch.given))
    else $error("decrease picked a size not below the given one");

  a_fit_within: assert property (@(posedge clk) disable iff (!rst_n)
    (srch.valid && srch.op == OP_FIT && srch.dn_found) |-> (srch.dn_idx <= srch.clamp_shift))
    else $error("fitting size larger than the clamped request");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for page_size_selector_unit: directed table, then random phases.
// Each phase loads a new size mask; results are compared with a local predictor.
// Depends on psz_pkg and the page_size_selector_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psz_pkg::*;

  localparam int PIPE_DEPTH = 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES = 14;
  localparam int PHASE_ITEMS = 125;

  // Reserved operation codes, expected to answer "not found"
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic               found;
  } size_pick_t;

  typedef struct packed {
    logic               is_mask_write;
    logic [DATA_W-1:0]  mask_val;
    logic [2:0]         op;
    logic [DATA_W-1:0]  bytes;
    logic [DATA_W-1:0]  addr;
    logic [SHIFT_W-1:0] given;
    logic               typed;
    size_pick_t         pick;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic [DATA_W-1:0] in_byte_count = '0;
  logic [DATA_W-1:0] in_start_address = '0;
  logic [SHIFT_W-1:0] in_given_shift = '0;
  logic out_valid;
  logic [SHIFT_W-1:0] out_size_shift;
  logic out_found;
  logic cfg_we = 1'b0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  logic [DATA_W-1:0] cur_mask;
  size_pick_t pending_picks[$];
  stim_row_t dir_tab[$];
  int n_err = 0;
  int n_results = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b0;

  page_size_selector_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_byte_count(in_byte_count),
    .in_start_address(in_start_address),
    .in_given_shift(in_given_shift),
    .out_valid(out_valid),
    .out_size_shift(out_size_shift),
    .out_found(out_found),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int msb_idx(logic [DATA_W-1:0] v);
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) return i;
    end
    return -1;
  endfunction

  function automatic int lsb_idx(logic [DATA_W-1:0] v);
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) return i;
    end
    return -1;
  endfunction

  // Nearest supported shift strictly above s, or -1
  function automatic int size_above(logic [DATA_W-1:0] m, int s);
    if (s >= 63) return -1;
    return lsb_idx(m & ~((64'd1 << (s + 1)) - 64'd1));
  endfunction

  // Nearest supported shift strictly below s, or -1
  function automatic int size_below(logic [DATA_W-1:0] m, int s);
    if (s == 0) return -1;
    if (s >= 64) return msb_idx(m);
    return msb_idx(m & ((64'd1 << s) - 64'd1));
  endfunction

  function automatic size_pick_t pick_page_size(logic [DATA_W-1:0] m, logic [2:0] op,
                                                logic [DATA_W-1:0] bytes,
                                                logic [DATA_W-1:0] addr,
                                                logic [SHIFT_W-1:0] given);
    int res;
    int s;
    int cap;
    int a;
    size_pick_t p;
    res = -1;
    if (m != '0) begin
      // round up to a power of two, then clamp to the supported range
      s = (bytes > 64'd1) ? msb_idx(bytes - 64'd1) + 1 : 0;
      if (s < lsb_idx(m)) s = lsb_idx(m);
      if (s > msb_idx(m)) s = msb_idx(m);
      case (op)
        OP_ENCOMPASS: res = m[s] ? s : size_above(m, s);
        OP_FIT:       res = m[s] ? s : size_below(m, s);
        OP_AT_ADDR: begin
          if (addr == '0) begin
            cap = msb_idx(m);
          end else begin
            a = lsb_idx(addr);
            cap = m[a] ? a : size_below(m, a);
          end
          if (cap < 0) res = -1;
          else if (s > cap) res = cap;
          else if (m[s]) res = s;
          else res = size_above(m, s);
        end
        OP_INCREASE:  res = size_above(m, int'(given));
        OP_DECREASE:  res = size_below(m, int'(given));
        default:      res = -1;
      endcase
    end
    p.found = (res >= 0);
    p.shift = (res >= 0) ? SHIFT_W'(res) : '0;
    return p;
  endfunction

  function automatic stim_row_t query_row(logic [2:0] op, logic [DATA_W-1:0] bytes,
                                          logic [DATA_W-1:0] addr,
                                          logic [SHIFT_W-1:0] given);
    stim_row_t r;
    r = '0;
    r.op = op;
    r.bytes = bytes;
    r.addr = addr;
    r.given = given;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [2:0] op, logic [DATA_W-1:0] bytes,
                                          logic [DATA_W-1:0] addr,
                                          logic [SHIFT_W-1:0] given,
                                          logic [SHIFT_W-1:0] shift, logic found);
    stim_row_t r;
    r = query_row(op, bytes, addr, given);
    r.typed = 1'b1;
    r.pick.shift = shift;
    r.pick.found = found;
    return r;
  endfunction

  function automatic stim_row_t mask_row(logic [DATA_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_mask_write = 1'b1;
    r.mask_val = v;
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; always back-to-back in burst mode
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Favor shifts that are set in the mask
  function automatic int pick_shift(logic [DATA_W-1:0] m);
    int k;
    for (int t = 0; t < 8; t++) begin
      k = $urandom_range(0, 63);
      if (m[k]) return k;
    end
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch on result %0d: %s", $realtime, n_results, msg);
    n_err++;
  endtask

  task automatic send_query(stim_row_t r);
    int gap;
    start <= 1'b1;
    in_operation <= r.op;
    in_byte_count <= r.bytes;
    in_start_address <= r.addr;
    in_given_shift <= r.given;
    do @(posedge clk); while (busy !== 1'b0);
    pending_picks.push_back(r.typed ? r.pick
        : pick_page_size(cur_mask, r.op, r.bytes, r.addr, r.given));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the pipeline, then load a new size mask
  task automatic write_size_mask(logic [DATA_W-1:0] v);
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mask = v;
  endtask

  function automatic logic [DATA_W-1:0] choose_mask(int phase);
    logic [DATA_W-1:0] m;
    int nbits;
    case (phase)
      0: m = MASK_RESET;
      1: m = ALL_ONES;
      2: m = 64'd1;
      3: m = TOP_BIT;
      4: m = TOP_BIT | 64'd1;
      default: begin
        case ($urandom_range(0, 2))
          0: m = 64'd1 << $urandom_range(0, 63);
          1: begin
            m = '0;
            nbits = $urandom_range(1, 4);
            for (int i = 0; i < nbits; i++) m[$urandom_range(0, 63)] = 1'b1;
          end
          default: m = rand_word();
        endcase
        if (m == '0) m = 64'd1;
      end
    endcase
    return m;
  endfunction

  task automatic run_random_phase(int n_items);
    stim_row_t r;
    int k;
    for (int i = 0; i < n_items; i++) begin
      r = '0;
      r.op = ($urandom_range(0, 99) < 4) ? 3'($urandom_range(OP_RSVD5, OP_RSVD7))
                                         : 3'($urandom_range(OP_ENCOMPASS, OP_DECREASE));
      k = pick_shift(cur_mask);
      case ($urandom_range(0, 5))
        0, 1: r.bytes = rand_word();
        2: r.bytes = 64'($urandom_range(0, 3));
        3: r.bytes = ($urandom_range(0, 1) == 1) ? ALL_ONES : TOP_BIT + 64'($urandom_range(0, 1));
        default: r.bytes = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
      endcase
      case ($urandom_range(0, 7))
        0: r.addr = '0;
        1, 2: r.addr = rand_word();
        default: begin
          k = pick_shift(cur_mask);
          r.addr = (rand_word() << (k + 1)) | (64'd1 << k);
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        r.given = 6'($urandom_range(0, 63));
      end else begin
        k = pick_shift(cur_mask) + $urandom_range(0, 2) - 1;
        if (k < 0) k = 0;
        if (k > 63) k = 63;
        r.given = 6'(k);
      end
      send_query(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result shift %0d found %0b",
                                  out_size_shift, out_found));
      end else begin
        size_pick_t want;
        want = pending_picks.pop_front();
        if (out_size_shift !== want.shift)
          report_mismatch($sformatf("size_shift got %0d want %0d", out_size_shift, want.shift));
        if (out_found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", out_found, want.found));
      end
    end
  end

  // Watchdog: any transaction, result or register write counts as progress
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // reset mask supports shifts 12, 21 and 30
    dir_tab.push_back(known_row(OP_ENCOMPASS, 64'd0, '0, '0, 6'd12, 1'b1));
    dir_tab.push_back(known_row(OP_ENCOMPASS, 64'd4097, '0, '0, 6'd21, 1'b1));
    dir_tab.push_back(known_row(OP_ENCOMPASS, ALL_ONES, '0, '0, 6'd30, 1'b1));
    dir_tab.push_back(known_row(OP_ENCOMPASS, TOP_BIT + 64'd1, '0, '0, 6'd30, 1'b1));
    dir_tab.push_back(query_row(OP_ENCOMPASS, 64'd1, ALL_ONES, 6'd63));
    dir_tab.push_back(known_row(OP_FIT, 64'h20_0001, '0, '0, 6'd21, 1'b1));
    dir_tab.push_back(known_row(OP_FIT, 64'd0, '0, '0, 6'd12, 1'b1));
    dir_tab.push_back(known_row(OP_AT_ADDR, 64'h4000_0000, 64'd0, '0, 6'd30, 1'b1));
    dir_tab.push_back(known_row(OP_AT_ADDR, 64'h4000_0000, 64'h20_0000, '0, 6'd21, 1'b1));
    // alignment below the smallest size
    dir_tab.push_back(known_row(OP_AT_ADDR, 64'd4096, 64'h800, '0, 6'd0, 1'b0));
    dir_tab.push_back(query_row(OP_AT_ADDR, 64'd4097, TOP_BIT, '0));
    dir_tab.push_back(known_row(OP_INCREASE, ALL_ONES, ALL_ONES, 6'd12, 6'd21, 1'b1));
    dir_tab.push_back(known_row(OP_INCREASE, '0, '0, 6'd30, 6'd0, 1'b0));
    dir_tab.push_back(query_row(OP_INCREASE, '0, '0, 6'd13));
    dir_tab.push_back(known_row(OP_INCREASE, '0, '0, 6'd63, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_DECREASE, '0, '0, 6'd12, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_DECREASE, '0, '0, 6'd63, 6'd30, 1'b1));
    dir_tab.push_back(known_row(OP_RSVD5, 64'd4096, '0, 6'd12, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_RSVD6, 64'd0, '0, 6'd30, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_RSVD7, ALL_ONES, ALL_ONES, 6'd63, 6'd0, 1'b0));
    // empty mask: nothing is ever found
    dir_tab.push_back(mask_row('0));
    dir_tab.push_back(known_row(OP_ENCOMPASS, ALL_ONES, '0, '0, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_AT_ADDR, 64'd4096, 64'd0, '0, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_INCREASE, '0, '0, 6'd0, 6'd0, 1'b0));
    dir_tab.push_back(known_row(OP_DECREASE, '0, '0, 6'd63, 6'd0, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    cur_mask = MASK_RESET;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_mask_write) write_size_mask(dir_tab[i].mask_val);
      else send_query(dir_tab[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_size_mask(choose_mask(p));
      burst_mode = ($urandom_range(0, 3) == 0);
      run_random_phase(PHASE_ITEMS);
    end

    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (n_err == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
